>>> hdl/avrexe_pkg.sv
`timescale 1ns / 1ps

package avrexe_pkg;

    // Status register bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;

    localparam int unsigned INSN_W  = 16;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned PAIR_W  = 4;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SREG_W  = 8;
    localparam int unsigned NPC_W   = 14;
    localparam int unsigned OUT_W   = 48;

    // What the execute stage hands back for one instruction
    typedef struct packed {
        logic                 legal;
        logic [REG_W-1:0]     dest_index;
        logic [VALUE_W-1:0]   dest_value;
        logic [PAIR_W-1:0]    wr_pair;
        logic [1:0]           wr_bytes;
        logic [VALUE_W-1:0]   wr_data;
        logic [SREG_W-1:0]    sreg;
    } alu_res_t;

    // Destination register of an instruction, as the encoding gives it
    function automatic logic [REG_W-1:0] dest_reg(input logic [INSN_W-1:0] op);
        logic [REG_W-1:0] d;
        d = op[8:4];
        if (op[15:8] == 8'h96) begin
            d = {2'b11, op[5:4], 1'b0};
        end else if (op[15:12] == 4'h7 || op[15:12] == 4'hE) begin
            d = {1'b1, op[7:4]};
        end
        return d;
    endfunction

    // Source register of a two-register instruction
    function automatic logic [REG_W-1:0] src_reg(input logic [INSN_W-1:0] op);
        return {op[9], op[3:0]};
    endfunction

endpackage

>>> hdl/avrexe_alu.sv
`timescale 1ns / 1ps

module avrexe_alu (
    input  logic [avrexe_pkg::INSN_W-1:0]  instruction,
    input  logic [avrexe_pkg::VALUE_W-1:0] pair_d,
    input  logic [avrexe_pkg::VALUE_W-1:0] pair_r,
    input  logic [avrexe_pkg::SREG_W-1:0]  sreg,
    output avrexe_pkg::alu_res_t           res
);
    import avrexe_pkg::*;

    logic [7:0]       hi;
    logic [REG_W-1:0] d;
    logic [REG_W-1:0] r;
    logic             is_add, is_adc, is_adiw, is_and, is_andi, is_ldi;
    logic [7:0]       rd, rr, imm, and_b, and_res;
    logic             cin;
    logic [8:0]       sum9;
    logic [4:0]       half5;
    logic             v8;
    logic [15:0]      adiw_res;
    logic             adiw_v;
    logic [SREG_W-1:0] s;

    assign hi      = instruction[15:8];
    assign d       = dest_reg(instruction);
    assign r       = src_reg(instruction);
    assign is_add  = (hi[7:2] == 6'b000011);
    assign is_adc  = (hi[7:2] == 6'b000111);
    assign is_adiw = (hi == 8'h96);
    assign is_and  = (hi[7:2] == 6'b001000);
    assign is_andi = (hi[7:4] == 4'h7);
    assign is_ldi  = (hi[7:4] == 4'hE);

    // Pick the operand bytes out of their pairs
    assign rd  = d[0] ? pair_d[15:8] : pair_d[7:0];
    assign rr  = r[0] ? pair_r[15:8] : pair_r[7:0];
    assign imm = {instruction[11:8], instruction[3:0]};

    // Byte add, with carry in for ADC
    assign cin   = is_adc & sreg[FLAG_C];
    assign sum9  = {1'b0, rd} + {1'b0, rr} + {8'b0, cin};
    assign half5 = {1'b0, rd[3:0]} + {1'b0, rr[3:0]} + {4'b0, cin};
    assign v8    = (rd[7] & rr[7] & ~sum9[7]) | (~rd[7] & ~rr[7] & sum9[7]);

    // Logical and, register or immediate operand
    assign and_b   = is_andi ? imm : rr;
    assign and_res = rd & and_b;

    // Word add on the upper register pairs
    assign adiw_res = pair_d + {10'b0, instruction[7:6], instruction[3:0]};
    assign adiw_v   = ~pair_d[15] & adiw_res[15];

    always_comb begin
        s            = sreg;
        res.legal    = 1'b1;
        res.dest_index = d;
        res.dest_value = '0;
        res.wr_pair  = d[4:1];
        res.wr_bytes = d[0] ? 2'b10 : 2'b01;
        res.wr_data  = '0;
        unique if (is_add || is_adc) begin
            s[FLAG_C] = sum9[8];
            s[FLAG_Z] = (sum9[7:0] == 8'h00);
            s[FLAG_N] = sum9[7];
            s[FLAG_V] = v8;
            s[FLAG_S] = sum9[7] ^ v8;
            s[FLAG_H] = half5[4];
            res.dest_value = {8'b0, sum9[7:0]};
        end else if (is_adiw) begin
            s[FLAG_V] = adiw_v;
            s[FLAG_N] = adiw_res[15];
            s[FLAG_S] = adiw_res[15] ^ adiw_v;
            s[FLAG_Z] = (adiw_res == 16'h0000);
            s[FLAG_C] = pair_d[15] & ~adiw_res[15];
            res.dest_value = adiw_res;
            res.wr_bytes   = 2'b11;
        end else if (is_and || is_andi) begin
            s[FLAG_V] = 1'b0;
            s[FLAG_N] = and_res[7];
            s[FLAG_S] = and_res[7];
            s[FLAG_Z] = (and_res == 8'h00);
            res.dest_value = {8'b0, and_res};
        end else if (is_ldi) begin
            res.dest_value = {8'b0, imm};
        end else begin
            // unsupported opcode: report it and touch nothing
            res.legal      = 1'b0;
            res.dest_index = '0;
            res.wr_bytes   = 2'b00;
        end
        res.sreg = s;
        res.wr_data = res.wr_bytes == 2'b11 ? res.dest_value
                                            : {res.dest_value[7:0], res.dest_value[7:0]};
    end

endmodule

>>> hdl/avr_alu_subset_execute_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata: instruction word
// m_        out  m_tvalid/m_tready   m_tdata: dest_index, dest_value, status_flags,
//                                    next_pc, illegal
//
// One instruction per clock while m_ is not stalled. A beat is taken into the operand
// stage while the register file is read; it then executes and loads the result register.
// A write-first bypass on the register file read lets back to back instructions
// depend on each other. Reset clears the register file valid bits, SREG and PC.
// A stall on m_ holds the result register and then the operand stage.
module avr_alu_subset_execute_unit #(
    parameter int unsigned PC_BITS = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [avrexe_pkg::INSN_W-1:0]   s_tdata,   // [15:0] instruction
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] dest_index, [20:5] dest_value, [28:21] status_flags,
    // [42:29] next_pc, [43] illegal, [47:44] zero
    output logic [avrexe_pkg::OUT_W-1:0]    m_tdata
);
    import avrexe_pkg::*;

    localparam int unsigned NPAIRS = 16;

    // Register file as 16 pairs, low and high byte
    logic [7:0] mem_lo [NPAIRS];
    logic [7:0] mem_hi [NPAIRS];
    logic [NPAIRS-1:0] vld_lo_reg, vld_hi_reg;

    logic                 op_valid_reg;
    logic [INSN_W-1:0]    op_insn_reg;
    logic [VALUE_W-1:0]   pair_d_reg, pair_r_reg;
    logic [SREG_W-1:0]    sreg_reg;
    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    logic                 s_fire, ex_fire, wr_en;
    logic [PAIR_W-1:0]    rd_pair_d, rd_pair_r;
    logic [REG_W-1:0]     dsel, rsel;
    alu_res_t             alu;

    assign ex_fire  = op_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready = ~op_valid_reg | ex_fire;
    assign s_fire   = s_tvalid & s_tready;
    assign wr_en    = ex_fire & alu.legal;

    assign dsel      = dest_reg(s_tdata);
    assign rsel      = src_reg(s_tdata);
    assign rd_pair_d = dsel[4:1];
    assign rd_pair_r = rsel[4:1];

    avrexe_alu u_alu (
        .instruction (op_insn_reg),
        .pair_d      (pair_d_reg),
        .pair_r      (pair_r_reg),
        .sreg        (sreg_reg),
        .res         (alu)
    );

    // Write the register file bytes
    always_ff @(posedge aclk) begin
        if (wr_en && alu.wr_bytes[0]) begin
            mem_lo[alu.wr_pair] <= alu.wr_data[7:0];
        end
        if (wr_en && alu.wr_bytes[1]) begin
            mem_hi[alu.wr_pair] <= alu.wr_data[15:8];
        end
    end

    // Track which bytes hold data since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_lo_reg <= '0;
            vld_hi_reg <= '0;
        end else if (wr_en) begin
            if (alu.wr_bytes[0]) vld_lo_reg[alu.wr_pair] <= 1'b1;
            if (alu.wr_bytes[1]) vld_hi_reg[alu.wr_pair] <= 1'b1;
        end
    end

    // Read both operand pairs on accept, forwarding a write on the same edge
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_insn_reg <= s_tdata;
            if (wr_en && alu.wr_bytes[0] && alu.wr_pair == rd_pair_d)
                pair_d_reg[7:0] <= alu.wr_data[7:0];
            else
                pair_d_reg[7:0] <= vld_lo_reg[rd_pair_d] ? mem_lo[rd_pair_d] : 8'h00;
            if (wr_en && alu.wr_bytes[1] && alu.wr_pair == rd_pair_d)
                pair_d_reg[15:8] <= alu.wr_data[15:8];
            else
                pair_d_reg[15:8] <= vld_hi_reg[rd_pair_d] ? mem_hi[rd_pair_d] : 8'h00;
            if (wr_en && alu.wr_bytes[0] && alu.wr_pair == rd_pair_r)
                pair_r_reg[7:0] <= alu.wr_data[7:0];
            else
                pair_r_reg[7:0] <= vld_lo_reg[rd_pair_r] ? mem_lo[rd_pair_r] : 8'h00;
            if (wr_en && alu.wr_bytes[1] && alu.wr_pair == rd_pair_r)
                pair_r_reg[15:8] <= alu.wr_data[15:8];
            else
                pair_r_reg[15:8] <= vld_hi_reg[rd_pair_r] ? mem_hi[rd_pair_r] : 8'h00;
        end
    end

    // Advance PC on legal instructions and pack the result beat
    always_comb begin
        pc_next = pc_reg + (alu.legal ? PC_BITS'(1) : PC_BITS'(0));
        m_data_next = {4'b0, ~alu.legal, NPC_W'(pc_next), alu.sreg,
                       alu.dest_value, alu.dest_index};
    end

    // Control state: operand stage, result stage, SREG, PC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sreg_reg     <= '0;
            pc_reg       <= '0;
        end else begin
            if (s_fire)
                op_valid_reg <= 1'b1;
            else if (ex_fire)
                op_valid_reg <= 1'b0;
            if (ex_fire) begin
                m_valid_reg <= 1'b1;
                sreg_reg    <= alu.sreg;
                pc_reg      <= pc_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> verif/avr_alu_subset_execute_unit_test.sv
`timescale 1ns / 1ps

module avr_alu_subset_execute_unit_test;
    import avrexe_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 1560;
    localparam int unsigned FULL_RATE_ITEMS = 64;
    localparam int unsigned SETTLE          = 16;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned MAX_REPORTS     = 40;

    // Opcode prefixes of the supported instructions
    localparam logic [5:0] OPC_ADD  = 6'b000011;
    localparam logic [5:0] OPC_ADC  = 6'b000111;
    localparam logic [5:0] OPC_AND  = 6'b001000;
    localparam logic [7:0] OPC_ADIW = 8'h96;
    localparam logic [3:0] OPC_ANDI = 4'h7;
    localparam logic [3:0] OPC_LDI  = 4'hE;

    // Words outside the supported set
    localparam logic [15:0] WORD_NOP  = 16'h0000;
    localparam logic [15:0] WORD_ONES = 16'hFFFF;
    localparam logic [15:0] WORD_SUB  = 16'h1800;
    localparam logic [15:0] WORD_EOR  = 16'h2400;
    localparam logic [15:0] WORD_SBIW = 16'h9700;
    localparam logic [15:0] WORD_SBC  = 16'h0BFF;

    typedef enum logic [2:0] {
        OP_ADD, OP_ADC, OP_ADIW, OP_AND, OP_ANDI, OP_LDI, OP_ILLEGAL
    } op_kind_t;

    // Same layout as m_tdata[43:0]
    typedef struct packed {
        logic                illegal;
        logic [NPC_W-1:0]    next_pc;
        logic [SREG_W-1:0]   status_flags;
        logic [VALUE_W-1:0]  dest_value;
        logic [REG_W-1:0]    dest_index;
    } avr_result_t;

    typedef struct packed {
        logic [INSN_W-1:0]  word;
        logic               known;
        avr_result_t        typed;
    } directed_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [INSN_W-1:0]    s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    // Shadow of the architectural state
    logic [7:0]           gpr [0:31];
    logic [SREG_W-1:0]    sreg_model;
    logic [NPC_W-1:0]     pc_model;

    avr_result_t          pending_results [$];
    directed_row_t        directed_rows [$];
    int unsigned          mismatches  = 0;
    int unsigned          cycle_count = 0;
    bit                   quiet       = 1'b0;
    int unsigned          tx_burst    = 0;
    int unsigned          rx_stall    = 0;
    int unsigned          rx_burst    = 0;

    avr_alu_subset_execute_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Build an instruction word; the illegal kind passes src through as is
    function automatic logic [15:0] encode(op_kind_t kind, logic [4:0] d, logic [15:0] src);
        case (kind)
            OP_ADD:  return {OPC_ADD, src[4], d, src[3:0]};
            OP_ADC:  return {OPC_ADC, src[4], d, src[3:0]};
            OP_AND:  return {OPC_AND, src[4], d, src[3:0]};
            OP_ADIW: return {OPC_ADIW, src[5:4], d[2:1], src[3:0]};
            OP_ANDI: return {OPC_ANDI, src[7:4], d[3:0], src[3:0]};
            OP_LDI:  return {OPC_LDI, src[7:4], d[3:0], src[3:0]};
            default: return src;
        endcase
    endfunction

    function automatic op_kind_t classify(logic [15:0] w);
        if (w[15:10] == OPC_ADD) begin
            return OP_ADD;
        end else if (w[15:10] == OPC_ADC) begin
            return OP_ADC;
        end else if (w[15:10] == OPC_AND) begin
            return OP_AND;
        end else if (w[15:8] == OPC_ADIW) begin
            return OP_ADIW;
        end else if (w[15:12] == OPC_ANDI) begin
            return OP_ANDI;
        end else if (w[15:12] == OPC_LDI) begin
            return OP_LDI;
        end
        return OP_ILLEGAL;
    endfunction

    // Execute one word against the shadow state and form its result beat
    task automatic execute_insn(input logic [15:0] w, output avr_result_t res);
        op_kind_t     kind;
        logic [4:0]   d;
        logic [4:0]   r;
        logic [7:0]   a;
        logic [7:0]   b;
        logic [7:0]   byte_res;
        logic [8:0]   sum;
        logic [4:0]   half;
        logic [15:0]  old;
        logic [15:0]  wide;
        logic         cin;
        logic         ovf;
        res  = '0;
        kind = classify(w);
        d    = w[8:4];
        r    = {w[9], w[3:0]};
        case (kind)
            OP_ADD, OP_ADC: begin
                cin  = (kind == OP_ADC) ? sreg_model[FLAG_C] : 1'b0;
                a    = gpr[d];
                b    = gpr[r];
                sum  = {1'b0, a} + {1'b0, b} + {8'b0, cin};
                half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
                byte_res = sum[7:0];
                ovf  = (a[7] & b[7] & ~byte_res[7]) | (~a[7] & ~b[7] & byte_res[7]);
                sreg_model[FLAG_C] = sum[8];
                sreg_model[FLAG_Z] = (byte_res == 8'h00);
                sreg_model[FLAG_N] = byte_res[7];
                sreg_model[FLAG_V] = ovf;
                sreg_model[FLAG_S] = byte_res[7] ^ ovf;
                sreg_model[FLAG_H] = half[4];
                gpr[d] = byte_res;
                res.dest_value = {8'h00, byte_res};
            end
            OP_AND, OP_ANDI: begin
                if (kind == OP_ANDI) begin
                    d = {1'b1, w[7:4]};
                    b = {w[11:8], w[3:0]};
                end else begin
                    b = gpr[r];
                end
                byte_res = gpr[d] & b;
                sreg_model[FLAG_V] = 1'b0;
                sreg_model[FLAG_N] = byte_res[7];
                sreg_model[FLAG_S] = byte_res[7];
                sreg_model[FLAG_Z] = (byte_res == 8'h00);
                gpr[d] = byte_res;
                res.dest_value = {8'h00, byte_res};
            end
            OP_ADIW: begin
                d    = {2'b11, w[5:4], 1'b0};
                old  = {gpr[d | 5'd1], gpr[d]};
                wide = old + {10'b0, w[7:6], w[3:0]};
                ovf  = ~old[15] & wide[15];
                sreg_model[FLAG_V] = ovf;
                sreg_model[FLAG_N] = wide[15];
                sreg_model[FLAG_S] = wide[15] ^ ovf;
                sreg_model[FLAG_Z] = (wide == 16'h0000);
                sreg_model[FLAG_C] = old[15] & ~wide[15];
                gpr[d]        = wide[7:0];
                gpr[d | 5'd1] = wide[15:8];
                res.dest_value = wide;
            end
            OP_LDI: begin
                d = {1'b1, w[7:4]};
                byte_res = {w[11:8], w[3:0]};
                gpr[d] = byte_res;
                res.dest_value = {8'h00, byte_res};
            end
            default: ;
        endcase
        if (kind != OP_ILLEGAL) begin
            pc_model = pc_model + 1'b1;
            res.dest_index = d;
        end else begin
            res.illegal = 1'b1;
        end
        res.status_flags = sreg_model;
        res.next_pc      = pc_model;
    endtask

    // Random word: mostly supported instructions, the rest any 16-bit value
    function automatic logic [15:0] rand_insn(bit legal_only);
        op_kind_t     kind;
        logic [4:0]   d;
        logic [15:0]  src;
        int unsigned  pick;
        if (!legal_only && $urandom_range(0, 99) < 14) begin
            return 16'($urandom_range(0, 16'hFFFF));
        end
        pick = $urandom_range(0, 6);
        kind = (pick == 6) ? OP_LDI : op_kind_t'(pick);
        src  = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       src = 16'h0000;
                1:       src = 16'h007F;
                2:       src = 16'h0080;
                default: src = 16'h00FF;
            endcase
        end
        case (kind)
            OP_ANDI, OP_LDI: d = 5'($urandom_range(16, 31));
            OP_ADIW:         d = 5'd24 + 5'($urandom_range(0, 3) * 2);
            default: begin
                d   = 5'($urandom_range(0, 31));
                src = 16'($urandom_range(0, 31));
            end
        endcase
        if (kind == OP_ADIW) begin
            src = 16'($urandom_range(0, 63));
        end
        return encode(kind, d, src);
    endfunction

    task automatic add_row(input logic [15:0] word, input bit known, input logic [4:0] d,
                           input logic [15:0] v, input logic [7:0] f,
                           input logic [NPC_W-1:0] pc, input logic ill);
        directed_row_t row;
        row.word               = word;
        row.known              = known;
        row.typed.dest_index   = d;
        row.typed.dest_value   = v;
        row.typed.status_flags = f;
        row.typed.next_pc      = pc;
        row.typed.illegal      = ill;
        directed_rows.push_back(row);
    endtask

    // Present one beat, record its expected result, then maybe idle
    task automatic send_insn(input logic [15:0] word, input bit known,
                             input avr_result_t typed);
        avr_result_t  predicted;
        int unsigned  gap;
        int unsigned  roll;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        execute_insn(word, predicted);
        pending_results.push_back(known ? typed : predicted);
        gap = 0;
        if (!quiet) begin
            if (tx_burst != 0) begin
                tx_burst--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    tx_burst = $urandom_range(20, 60);
                end else if (roll < 55) begin
                    gap = 0;
                end else if (roll < 92) begin
                    gap = $urandom_range(1, 3);
                end else begin
                    gap = $urandom_range(8, 40);
                end
            end
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
        mismatches++;
    endtask

    // Pace the result side: short and long stalls, plus stall-free runs
    always @(posedge aclk) begin : rx_pace
        int unsigned roll;
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else if (rx_burst != 0) begin
            m_tready <= 1'b1;
            rx_burst--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                m_tready <= 1'b1;
                rx_burst = $urandom_range(30, 80);
            end else if (roll < 65) begin
                m_tready <= 1'b1;
            end else if (roll < 93) begin
                m_tready <= 1'b0;
                rx_stall = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_stall = $urandom_range(8, 40);
            end
        end
    end

    // Compare each result beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        avr_result_t seen;
        avr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[43:0];
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: result beat with nothing expected, actual 0x%0h",
                             $time, seen);
                end
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (seen.dest_index !== want.dest_index)
                    report("dest_index", want.dest_index, seen.dest_index);
                if (seen.dest_value !== want.dest_value)
                    report("dest_value", want.dest_value, seen.dest_value);
                if (seen.status_flags !== want.status_flags)
                    report("status_flags", want.status_flags, seen.status_flags);
                if (seen.next_pc !== want.next_pc)
                    report("next_pc", want.next_pc, seen.next_pc);
                if (seen.illegal !== want.illegal)
                    report("illegal", want.illegal, seen.illegal);
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        directed_row_t  row;
        for (int i = 0; i < 32; i++) gpr[i] = 8'h00;
        sreg_model = '0;
        pc_model   = '0;

        // Straight out of reset, extremes and rejected words have their results typed in
        add_row(encode(OP_ILLEGAL, 0, WORD_NOP), 1, 0, 16'h0000, 8'h00, 0, 1);
        add_row(encode(OP_ADD, 0, 0),            1, 0, 16'h0000, 8'h02, 1, 0);
        add_row(encode(OP_LDI, 16, 16'hFF),      1, 16, 16'h00FF, 8'h02, 2, 0);
        add_row(encode(OP_LDI, 31, 16'h80),      1, 31, 16'h0080, 8'h02, 3, 0);
        // 0xFF + 0xFF: C, N, S, H
        add_row(encode(OP_ADD, 16, 16),          1, 16, 16'h00FE, 8'h35, 4, 0);
        // 0x80 + 0x80 + carry: C, V, S
        add_row(encode(OP_ADC, 31, 31),          1, 31, 16'h0001, 8'h19, 5, 0);
        add_row(encode(OP_ILLEGAL, 0, WORD_ONES), 1, 0, 16'h0000, 8'h19, 5, 1);
        // Word add through 0xFFFF and through 0x7FFF
        add_row(encode(OP_LDI, 24, 16'hFF), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_LDI, 25, 16'hFF), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ADIW, 24, 63),    0, 0, 0, 0, 0, 0);
        add_row(encode(OP_LDI, 27, 16'h7F), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_LDI, 26, 16'hFF), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ADIW, 26, 1),     0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ADIW, 30, 0),     0, 0, 0, 0, 0, 0);
        // Logic ops keep C and H, clear V
        add_row(encode(OP_AND, 16, 31),     0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ANDI, 16, 16'h00), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ANDI, 31, 16'hFF), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_AND, 0, 0),       0, 0, 0, 0, 0, 0);
        // Carry-in alone produces the half carry
        add_row(encode(OP_LDI, 17, 16'h0F), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_LDI, 19, 16'h80), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ADD, 19, 19),     0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ADC, 17, 18),     0, 0, 0, 0, 0, 0);
        // Neighbors of supported opcodes
        add_row(encode(OP_ILLEGAL, 0, WORD_SUB),  0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ILLEGAL, 0, WORD_EOR),  0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ILLEGAL, 0, WORD_SBIW), 0, 0, 0, 0, 0, 0);
        add_row(encode(OP_ILLEGAL, 0, WORD_SBC),  0, 0, 0, 0, 0, 0);

        // Hold reset, then release it
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_insn(row.word, row.known, row.typed);
        end

        // Random instruction stream; stop once halfway until every result is back
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_results();
            send_insn(rand_insn(0), 0, '0);
        end

        // Run a stretch of dependent instructions at full rate on both sides
        drain_results();
        quiet = 1'b1;
        repeat (FULL_RATE_ITEMS) send_insn(rand_insn(1), 0, '0);
        quiet = 1'b0;

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
